FILE: sv/mscel_pkg.sv
// Shared types, constants and the softplus table of the sigmoid cross-entropy loss block.
package mscel_pkg;

  localparam int MAX_TASKS  = 256;
  localparam int POS_W      = $clog2(MAX_TASKS);
  localparam int LOGIT_W    = 16;
  localparam int LOSS_W     = 24;
  localparam int SUM_W      = 48;
  localparam int COUNT_W    = 16;
  localparam int DIV_STEPS  = SUM_W;
  localparam int DIV_CNT_W  = $clog2(DIV_STEPS);
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int SP_ENTRIES = 256;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;

  // Register indexes of the configuration port.
  localparam logic [CFG_IDX_W-1:0] CFG_ONE_HOT_MODE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_COUNT = 1'd1;

  // Masked-mode target code for a positive label.
  localparam logic [1:0] TARGET_POS  = 2'b01;
  localparam logic [1:0] TARGET_SKIP = 2'b00;

  typedef logic [15:0] sp_tab_t [SP_ENTRIES];

  // One classified element on its way from the front to the back.
  typedef struct packed {
    logic [LOSS_W-1:0] loss;
    logic              end_batch;
  } mscel_item_t;

  // Request to the divider and its answer.
  typedef struct packed {
    logic             start;
    logic [SUM_W-1:0] dividend;
    logic [COUNT_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [SUM_W-1:0] quotient;
  } div_rsp_t;

  typedef enum logic [1:0] {
    BK_ACC,
    BK_DIV,
    BK_WAIT
  } back_state_t;

  // Unsigned quotient by shift and subtract; only ever evaluated while the table is built.
  function automatic logic [63:0] quot64(input logic [63:0] num, input logic [63:0] den);
    logic [63:0] rem;
    logic [63:0] quo;
    rem = '0;
    quo = '0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[62:0], num[b]};
      quo = quo << 1;
      if (rem >= den) begin
        rem    = rem - den;
        quo[0] = 1'b1;
      end
    end
    return quo;
  endfunction

  // Entry i is ln(1 + exp(-i/16)) in Q0.16, worked out at elaboration in Q32 integer arithmetic.
  function automatic sp_tab_t build_sp_table();
    logic [63:0] t;
    logic [63:0] s;
    logic [63:0] c;
    logic [63:0] e;
    logic [63:0] z;
    logic [63:0] z2;
    logic [63:0] p;
    logic [63:0] acc;
    logic [63:0] l;
    sp_tab_t     tab;
    t = 64'd1 << 60;
    s = t;
    for (int k = 1; k <= 14; k++) begin
      t = quot64(t, 64'd16 * 64'(k));
      if (k[0]) begin
        s = s - t;
      end else begin
        s = s + t;
      end
    end
    c = (s + (64'd1 << 27)) >> 28;
    e = 64'd1 << 32;
    for (int i = 0; i < SP_ENTRIES; i++) begin
      z   = quot64(e << 31, (64'd2 << 32) + e) << 1;
      z2  = (z * z) >> 32;
      p   = z;
      acc = z;
      for (int k = 3; k <= 41; k += 2) begin
        p   = (p * z2) >> 32;
        acc = acc + quot64(p, 64'(k));
      end
      l      = acc << 1;
      tab[i] = 16'((l + (64'd1 << 15)) >> 16);
      e      = (e * c + (64'd1 << 31)) >> 32;
    end
    return tab;
  endfunction

  localparam sp_tab_t SP_TABLE = build_sp_table();

endpackage

FILE: sv/mscel_front.sv
// Front end: accepts logits, tracks the element position and works out each element's loss.
module mscel_front (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            one_hot_mode,
  input  logic                            accept,
  input  logic signed [15:0]              logit,
  input  logic signed [1:0]               target_sign,
  input  logic [7:0]                      class_index,
  input  logic                            last_in_sample,
  input  logic                            last_in_batch,
  output mscel_pkg::mscel_item_t          item
);

  logic [mscel_pkg::POS_W-1:0] pos_r;
  logic [mscel_pkg::POS_W-1:0] pos_nxt;
  logic                        x_neg;
  logic [15:0]                 mag;
  logic [7:0]                  sp_idx;
  logic                        counted;
  logic                        positive;
  logic [mscel_pkg::LOSS_W-1:0] loss;

  always_comb begin
    x_neg = logit[15];
    mag   = x_neg ? 16'(~logit + 16'sd1) : 16'(logit);
    // |x| is clipped below 16 and taken in steps of 1/16.
    sp_idx = (mag > 16'd4095) ? 8'hFF : mag[11:4];
    if (one_hot_mode) begin
      counted  = 1'b1;
      positive = (32'(class_index) == 32'(pos_r));
    end else begin
      counted  = (target_sign != mscel_pkg::TARGET_SKIP);
      positive = (target_sign == mscel_pkg::TARGET_POS);
    end
    loss = mscel_pkg::LOSS_W'(mscel_pkg::SP_TABLE[sp_idx]);
    if (positive == x_neg) begin
      loss = loss + {mag, 8'b0};
    end
    item.loss      = counted ? loss : '0;
    item.end_batch = last_in_batch;
  end

  always_comb begin
    pos_nxt = pos_r;
    if (accept) begin
      if (last_in_sample || last_in_batch ||
          (32'(pos_r) == mscel_pkg::MAX_TASKS - 1)) begin
        pos_nxt = '0;
      end else begin
        pos_nxt = pos_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
    end else begin
      pos_r <= pos_nxt;
    end
  end

endmodule

FILE: sv/mscel_fifo.sv
// Short queue of classified elements between the front and the back.
module mscel_fifo (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   push,
  input  mscel_pkg::mscel_item_t push_item,
  output logic                   full,
  input  logic                   pop,
  output mscel_pkg::mscel_item_t pop_item,
  output logic                   not_empty
);

  mscel_pkg::mscel_item_t              mem_r [mscel_pkg::FIFO_DEPTH];
  logic [mscel_pkg::FIFO_PTR_W-1:0]    wr_ptr_r;
  logic [mscel_pkg::FIFO_PTR_W-1:0]    wr_ptr_nxt;
  logic [mscel_pkg::FIFO_PTR_W-1:0]    rd_ptr_r;
  logic [mscel_pkg::FIFO_PTR_W-1:0]    rd_ptr_nxt;
  logic [mscel_pkg::FIFO_PTR_W:0]      cnt_r;
  logic [mscel_pkg::FIFO_PTR_W:0]      cnt_nxt;

  assign full      = (32'(cnt_r) == mscel_pkg::FIFO_DEPTH);
  assign not_empty = (cnt_r != '0);
  assign pop_item  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (32'(wr_ptr_r) == mscel_pkg::FIFO_DEPTH - 1) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (32'(rd_ptr_r) == mscel_pkg::FIFO_DEPTH - 1) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

FILE: sv/mscel_div.sv
// Restoring divider: one quotient bit per cycle for the batch mean.
module mscel_div (
  input  logic                  clk,
  input  logic                  rst_n,
  input  mscel_pkg::div_req_t   req,
  output mscel_pkg::div_rsp_t   rsp
);

  logic                                busy_r;
  logic                                busy_nxt;
  logic                                done_r;
  logic                                done_nxt;
  logic [mscel_pkg::DIV_CNT_W-1:0]     cnt_r;
  logic [mscel_pkg::DIV_CNT_W-1:0]     cnt_nxt;
  logic [mscel_pkg::SUM_W-1:0]         quo_r;
  logic [mscel_pkg::SUM_W-1:0]         quo_nxt;
  logic [mscel_pkg::COUNT_W-1:0]       rem_r;
  logic [mscel_pkg::COUNT_W-1:0]       rem_nxt;
  logic [mscel_pkg::COUNT_W-1:0]       dvs_r;
  logic [mscel_pkg::COUNT_W-1:0]       dvs_nxt;
  logic [mscel_pkg::COUNT_W:0]         trial;
  logic                                ge;

  assign rsp.done     = done_r;
  assign rsp.quotient = quo_r;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    trial    = {rem_r, quo_r[mscel_pkg::SUM_W-1]};
    ge       = (trial >= {1'b0, dvs_r});
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      quo_nxt  = req.dividend;
      rem_nxt  = '0;
      dvs_nxt  = req.divisor;
    end else if (busy_r) begin
      rem_nxt = ge ? mscel_pkg::COUNT_W'(trial - {1'b0, dvs_r})
                   : trial[mscel_pkg::COUNT_W-1:0];
      quo_nxt = {quo_r[mscel_pkg::SUM_W-2:0], ge};
      cnt_nxt = cnt_r + 1'b1;
      if (32'(cnt_r) == mscel_pkg::DIV_STEPS - 1) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

endmodule

FILE: sv/mscel_back.sv
// Back end: saturating loss accumulator, batch-end control and the result register.
module mscel_back (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic [mscel_pkg::COUNT_W-1:0]    sample_count,
  input  mscel_pkg::mscel_item_t           item,
  input  logic                             item_valid,
  output logic                             pop,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [mscel_pkg::SUM_W-1:0]      out_mean_loss
);

  mscel_pkg::back_state_t          state_r;
  mscel_pkg::back_state_t          state_nxt;
  logic [mscel_pkg::SUM_W-1:0]     sum_r;
  logic [mscel_pkg::SUM_W-1:0]     sum_nxt;
  logic [mscel_pkg::SUM_W:0]       sum_wide;
  logic [mscel_pkg::SUM_W-1:0]     sum_sat;
  logic                            out_valid_r;
  logic                            out_valid_nxt;
  logic [mscel_pkg::SUM_W-1:0]     out_data_r;
  logic                            slot_free;
  logic                            load_out;
  mscel_pkg::div_req_t             div_req;
  mscel_pkg::div_rsp_t             div_rsp;

  mscel_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  assign slot_free     = !out_valid_r || out_ready;
  assign out_valid     = out_valid_r;
  assign out_mean_loss = out_data_r;

  always_comb begin
    sum_wide = {1'b0, sum_r} + (mscel_pkg::SUM_W + 1)'(item.loss);
    sum_sat  = sum_wide[mscel_pkg::SUM_W] ? '1 : sum_wide[mscel_pkg::SUM_W-1:0];
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      mscel_pkg::BK_ACC: begin
        if (item_valid && item.end_batch) begin
          state_nxt = mscel_pkg::BK_DIV;
        end
      end
      mscel_pkg::BK_DIV: begin
        if (div_rsp.done) begin
          state_nxt = slot_free ? mscel_pkg::BK_ACC : mscel_pkg::BK_WAIT;
        end
      end
      mscel_pkg::BK_WAIT: begin
        if (slot_free) begin
          state_nxt = mscel_pkg::BK_ACC;
        end
      end
      default: state_nxt = mscel_pkg::BK_ACC;
    endcase
  end

  // Outputs of the state machine.
  always_comb begin
    pop              = 1'b0;
    load_out         = 1'b0;
    div_req.start    = 1'b0;
    div_req.dividend = sum_sat;
    div_req.divisor  = (sample_count == '0) ? mscel_pkg::COUNT_W'(1) : sample_count;
    unique case (state_r)
      mscel_pkg::BK_ACC: begin
        pop           = item_valid;
        div_req.start = item_valid && item.end_batch;
      end
      mscel_pkg::BK_DIV: begin
        load_out = div_rsp.done && slot_free;
      end
      mscel_pkg::BK_WAIT: begin
        load_out = slot_free;
      end
      default: begin
        pop = 1'b0;
      end
    endcase
  end

  always_comb begin
    sum_nxt = sum_r;
    if (pop) begin
      sum_nxt = item.end_batch ? '0 : sum_sat;
    end
    out_valid_nxt = out_valid_r;
    if (load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= mscel_pkg::BK_ACC;
      sum_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      sum_r       <= sum_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_data_r <= div_rsp.quotient;
    end
  end

endmodule

FILE: sv/masked_sigmoid_cross_entropy_loss_top.sv
// Top level of the masked sigmoid cross-entropy loss block: ports, configuration and wiring.
//
//   Channel   Direction  Handshake               Carries
//   in_*      request    in_valid / in_ready     logit, target, class index, sample/batch ends
//   out_*     result     out_valid / out_ready   mean loss of the batch (Q32.16)
//   cfg_*     write      cfg_valid / cfg_ready   register index and data
//
// The front takes one request per clock cycle for as long as the four-entry queue has room;
// it looks the softplus term up and forms the element loss in the same cycle.
// The back adds one element per cycle into the saturating sum while it is accumulating. The
// last element of a batch starts the bit-serial divider, which holds the back until the
// answer is ready; requests keep entering the queue meanwhile, as long as it has room.
// A finished mean sits in the result register until taken, while the back goes on with the
// next batch; only a second mean finishing while the first still waits stalls the back.
// Reset (synchronous, rst_n low) clears the sum, element position, queue and result valid;
// the mode returns to masked and the sample count to one. Configuration is always accepted.
module masked_sigmoid_cross_entropy_loss_top (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic signed [15:0]                   in_logit,
  input  logic signed [1:0]                    in_target_sign,
  input  logic [7:0]                           in_class_index,
  input  logic                                 in_last_in_sample,
  input  logic                                 in_last_in_batch,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [47:0]                          out_mean_loss,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [mscel_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [mscel_pkg::CFG_DATA_W-1:0]     cfg_data
);

  logic                              one_hot_mode_r;
  logic [mscel_pkg::COUNT_W-1:0]     sample_count_r;
  logic                              in_accept;
  logic                              fifo_full;
  logic                              fifo_not_empty;
  logic                              fifo_pop;
  mscel_pkg::mscel_item_t            front_item;
  mscel_pkg::mscel_item_t            back_item;

  // Writes land at once; the user must write only while the block is idle, as the block has no check for it.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      one_hot_mode_r <= 1'b0;
      sample_count_r <= mscel_pkg::COUNT_W'(1);
    end else if (cfg_valid) begin
      unique case (cfg_index)
        mscel_pkg::CFG_ONE_HOT_MODE: one_hot_mode_r <= cfg_data[0];
        mscel_pkg::CFG_SAMPLE_COUNT: sample_count_r <= cfg_data;
        default:                     one_hot_mode_r <= one_hot_mode_r;
      endcase
    end
  end

  // A request is taken whenever the queue can hold its element.
  assign in_ready  = !fifo_full;
  assign in_accept = in_valid && in_ready;

  mscel_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .one_hot_mode   (one_hot_mode_r),
    .accept         (in_accept),
    .logit          (in_logit),
    .target_sign    (in_target_sign),
    .class_index    (in_class_index),
    .last_in_sample (in_last_in_sample),
    .last_in_batch  (in_last_in_batch),
    .item           (front_item)
  );

  mscel_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_accept),
    .push_item (front_item),
    .full      (fifo_full),
    .pop       (fifo_pop),
    .pop_item  (back_item),
    .not_empty (fifo_not_empty)
  );

  mscel_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .sample_count  (sample_count_r),
    .item          (back_item),
    .item_valid    (fifo_not_empty),
    .pop           (fifo_pop),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_mean_loss (out_mean_loss)
  );

endmodule

FILE: dv/tb_top.sv
// Self-checking testbench of the masked sigmoid cross-entropy loss block.
module tb_top;

  // Negative target codes of the masked mode; the odd code 2'b10 also counts as negative.
  localparam logic [1:0]  TGT_NEG      = 2'b11;
  localparam logic [1:0]  TGT_NEG_ALT  = 2'b10;
  localparam logic [47:0] SUM_MAX      = '1;
  // A batch end holds the back for the whole division; the queue and result register add to the wait.
  localparam int          DRAIN_CYCLES = 120;
  localparam int          HOLD_CYCLES  = 300;
  localparam int          CYCLE_LIMIT  = 400000;
  localparam int          NUM_DIRECTED = 26;

  localparam logic [15:0] LIMIT_LOGITS [8] = '{16'h8000, 16'h8001, 16'h7FFF, 16'h0000,
                                                16'hFFFF, 16'h0FFF, 16'h1000, 16'hF000};

  // One line of the directed table: either a register update or a request, the latter
  // optionally carrying a mean that can be worked out by hand.
  typedef struct packed {
    logic        is_regs;
    logic        mode;
    logic [15:0] count;
    logic [15:0] logit;
    logic [1:0]  tgt;
    logic [7:0]  cls;
    logic        eos;
    logic        eob;
    logic        typed;
    logic [47:0] mean;
  } step_row_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [15:0] in_logit;
  logic [1:0]  in_target_sign;
  logic [7:0]  in_class_index;
  logic        in_last_in_sample;
  logic        in_last_in_batch;
  logic        out_valid;
  logic        out_ready;
  logic [47:0] out_mean_loss;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [mscel_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [mscel_pkg::CFG_DATA_W-1:0] cfg_data;

  // Predicted state of the block and its registers.
  logic [15:0] softplus_q16 [256];
  logic [47:0] acc_loss      = '0;
  int          elem_pos      = 0;
  logic        mode_one_hot  = 1'b0;
  logic [15:0] batch_samples = 16'd1;

  logic [47:0] pending_means [$];
  int          err_count   = 0;
  int          cycle_count = 0;
  int          tx_idle_pct = 38;
  int          rx_idle_pct = 80;
  logic        hold_off_req = 1'b0;
  int          hold_left    = 0;

  // Generator of well-formed batches: samples of a few elements, now and then a very long one
  // so that the element position wraps.
  int          gen_samples_left = 0;
  int          gen_elems_left   = 0;
  logic [7:0]  gen_class        = '0;
  logic        force_long       = 1'b0;

  step_row_t   directed_steps [NUM_DIRECTED];

  masked_sigmoid_cross_entropy_loss_top uut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_logit          (in_logit),
    .in_target_sign    (in_target_sign),
    .in_class_index    (in_class_index),
    .in_last_in_sample (in_last_in_sample),
    .in_last_in_batch  (in_last_in_batch),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_mean_loss     (out_mean_loss),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  always #5 clk = ~clk;

  // ln(1 + exp(-i/16)) in Q0.16: exp(-1/16) from its Taylor series, then ln(1+y) through
  // 2*atanh(y/(2+y)), all in Q32 integer arithmetic with the same rounding at every step.
  function automatic void fill_softplus();
    logic [63:0] term;
    logic [63:0] series;
    logic [63:0] decay;
    logic [63:0] ex;
    logic [63:0] z;
    logic [63:0] zsq;
    logic [63:0] pw;
    logic [63:0] acc;
    logic [63:0] ln;
    term   = 64'd1 << 60;
    series = term;
    for (int k = 1; k <= 14; k++) begin
      term   = term / (64'd16 * 64'(k));
      series = k[0] ? series - term : series + term;
    end
    decay = (series + (64'd1 << 27)) >> 28;
    ex    = 64'd1 << 32;
    for (int i = 0; i < 256; i++) begin
      z   = ((ex << 31) / ((64'd2 << 32) + ex)) << 1;
      zsq = (z * z) >> 32;
      pw  = z;
      acc = z;
      for (int k = 3; k <= 41; k += 2) begin
        pw  = (pw * zsq) >> 32;
        acc = acc + pw / 64'(k);
      end
      ln              = acc << 1;
      softplus_q16[i] = 16'((ln + (64'd1 << 15)) >> 16);
      ex              = (ex * decay + (64'd1 << 31)) >> 32;
    end
  endfunction

  // Folds one accepted request into the predicted sum; returns 1 with the mean on a batch end.
  function automatic logic fold_element_loss(input logic [15:0] x, input logic [1:0] tgt,
                                             input logic [7:0] cls, input logic eos,
                                             input logic eob, output logic [47:0] mean);
    logic        neg;
    logic [16:0] mag;
    logic [11:0] clipped;
    logic        counted;
    logic        label_pos;
    logic [48:0] term;
    logic [48:0] grown;
    neg  = x[15];
    mag  = neg ? (17'h10000 - {1'b0, x}) : {1'b0, x};
    mean = '0;
    if (mode_one_hot) begin
      counted   = 1'b1;
      label_pos = (int'(cls) == elem_pos);
    end else begin
      counted   = (tgt != mscel_pkg::TARGET_SKIP);
      label_pos = (tgt == mscel_pkg::TARGET_POS);
    end
    if (counted) begin
      clipped = (mag > 17'd4095) ? 12'hFFF : mag[11:0];
      term    = 49'(softplus_q16[clipped[11:4]]);
      // A wrong sign costs the full magnitude on top of the softplus term.
      if (label_pos == neg) begin
        term = term + (49'(mag) << 8);
      end
      grown    = {1'b0, acc_loss} + term;
      acc_loss = (grown > {1'b0, SUM_MAX}) ? SUM_MAX : grown[47:0];
    end
    elem_pos = elem_pos + 1;
    if (elem_pos >= mscel_pkg::MAX_TASKS) begin
      elem_pos = 0;
    end
    if (eos || eob) begin
      elem_pos = 0;
    end
    if (!eob) begin
      return 1'b0;
    end
    mean     = acc_loss / ((batch_samples == 16'd0) ? 48'd1 : 48'(batch_samples));
    acc_loss = '0;
    return 1'b1;
  endfunction

  function automatic step_row_t row_req(input logic [15:0] x, input logic [1:0] t,
                                        input logic [7:0] c, input logic es, input logic eb);
    step_row_t r;
    r       = '0;
    r.logit = x;
    r.tgt   = t;
    r.cls   = c;
    r.eos   = es;
    r.eob   = eb;
    return r;
  endfunction

  function automatic step_row_t row_chk(input logic [15:0] x, input logic [1:0] t,
                                        input logic [7:0] c, input logic es, input logic eb,
                                        input logic [47:0] m);
    step_row_t r;
    r       = row_req(x, t, c, es, eb);
    r.typed = 1'b1;
    r.mean  = m;
    return r;
  endfunction

  function automatic step_row_t row_regs(input logic m, input logic [15:0] n);
    step_row_t r;
    r         = '0;
    r.is_regs = 1'b1;
    r.mode    = m;
    r.count   = n;
    return r;
  endfunction

  function automatic logic [15:0] pick_logit();
    case ($urandom_range(9))
      0:          return LIMIT_LOGITS[$urandom_range(7)];
      1, 2, 3, 4: return 16'($urandom_range(8190)) - 16'd4095;
      default:    return 16'($urandom);
    endcase
  endfunction

  function automatic void draw_request(output logic [15:0] x, output logic [1:0] tgt,
                                       output logic [7:0] cls, output logic eos,
                                       output logic eob);
    int roll;
    int len;
    x    = pick_logit();
    roll = $urandom_range(99);
    tgt  = (roll < 40) ? mscel_pkg::TARGET_POS : (roll < 75) ? TGT_NEG :
           (roll < 85) ? TGT_NEG_ALT : mscel_pkg::TARGET_SKIP;
    // A few requests are plain noise that cuts samples and batches at random.
    if ($urandom_range(99) < 8) begin
      tgt = 2'($urandom);
      cls = 8'($urandom);
      eos = 1'($urandom);
      eob = ($urandom_range(3) == 0);
      return;
    end
    if (gen_elems_left == 0) begin
      if (gen_samples_left == 0) begin
        gen_samples_left = $urandom_range(1, 4);
      end
      if (force_long || $urandom_range(399) == 0) begin
        len        = $urandom_range(250, 300);
        force_long = 1'b0;
      end else begin
        len = $urandom_range(1, 8);
      end
      gen_elems_left = len;
      gen_class      = ($urandom_range(9) == 0) ? 8'($urandom) : 8'($urandom_range(len - 1));
    end
    cls            = gen_class;
    gen_elems_left = gen_elems_left - 1;
    eos            = (gen_elems_left == 0);
    eob            = eos && (gen_samples_left == 1);
    if (eos) begin
      gen_samples_left = gen_samples_left - 1;
    end
  endfunction

  // Offers one request after a random gap, holds it until taken and predicts its effect.
  task automatic send_request(input logic [15:0] x, input logic [1:0] tgt, input logic [7:0] cls,
                              input logic eos, input logic eob, input logic typed,
                              input logic [47:0] typed_mean);
    logic [47:0] mean;
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid          <= 1'b1;
    in_logit          <= x;
    in_target_sign    <= tgt;
    in_class_index    <= cls;
    in_last_in_sample <= eos;
    in_last_in_batch  <= eob;
    do @(posedge clk); while (!in_ready);
    if (fold_element_loss(x, tgt, cls, eos, eob, mean)) begin
      pending_means = {pending_means, (typed ? typed_mean : mean)};
    end
  endtask

  // Both registers are written back to back with the write valid held high between them.
  task automatic program_regs(input logic mode, input logic [15:0] count);
    cfg_valid <= 1'b1;
    cfg_index <= mscel_pkg::CFG_ONE_HOT_MODE;
    cfg_data  <= {15'($urandom), mode};
    do @(posedge clk); while (!cfg_ready);
    mode_one_hot = mode;
    cfg_index <= mscel_pkg::CFG_SAMPLE_COUNT;
    cfg_data  <= count;
    do @(posedge clk); while (!cfg_ready);
    batch_samples = count;
    cfg_valid <= 1'b0;
  endtask

  // Lets every expected mean come out and the back of the block settle.
  task automatic quiet_down();
    in_valid <= 1'b0;
    while (pending_means.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic random_phase(input int tx, input int rx, input logic mode,
                              input logic [15:0] count, input int n, input logic want_long);
    logic [15:0] x;
    logic [1:0]  t;
    logic [7:0]  c;
    logic        es;
    logic        eb;
    quiet_down();
    program_regs(mode, count);
    tx_idle_pct = tx;
    rx_idle_pct = rx;
    force_long  = want_long;
    repeat (n) begin
      draw_request(x, t, c, es, eb);
      send_request(x, t, c, es, eb, 1'b0, '0);
    end
  endtask

  // Receiver: random stalls, and on request one long hold-off counted here.
  always @(posedge clk) begin
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_ready <= 1'b0;
    end else if (hold_off_req) begin
      hold_off_req = 1'b0;
      hold_left    = HOLD_CYCLES - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // Every mean taken is compared with the oldest one predicted.
  always @(posedge clk) begin
    logic [47:0] want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_means.size() == 0) begin
        err_count = err_count + 1;
        $display("%0t: mean_loss expected none, actual %0d", $time, out_mean_loss);
      end else begin
        want = pending_means.pop_front();
        if (want !== out_mean_loss) begin
          err_count = err_count + 1;
          $display("%0t: mean_loss expected %0d, actual %0d", $time, want, out_mean_loss);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    logic eb;
    rst_n             = 1'b0;
    in_valid          = 1'b0;
    in_logit          = '0;
    in_target_sign    = '0;
    in_class_index    = '0;
    in_last_in_sample = 1'b0;
    in_last_in_batch  = 1'b0;
    out_ready         = 1'b0;
    cfg_valid         = 1'b0;
    cfg_index         = mscel_pkg::CFG_ONE_HOT_MODE;
    cfg_data          = '0;
    fill_softplus();

    // Means typed in by hand: softplus of a clipped magnitude rounds to zero, and a wrong
    // sign at full scale adds the magnitude shifted into Q.16.
    directed_steps = '{
      row_chk(16'h0000, mscel_pkg::TARGET_SKIP, 8'd0, 1'b1, 1'b1, 48'd0),
      row_chk(16'h8000, mscel_pkg::TARGET_POS, 8'd0, 1'b0, 1'b1, 48'd8388608),
      row_chk(16'h7FFF, TGT_NEG, 8'd0, 1'b0, 1'b1, 48'd8388352),
      row_chk(16'h7FFF, TGT_NEG_ALT, 8'd0, 1'b0, 1'b1, 48'd8388352),
      row_chk(16'h8000, TGT_NEG, 8'd0, 1'b0, 1'b1, 48'd0),
      row_chk(16'h7FFF, mscel_pkg::TARGET_POS, 8'd0, 1'b0, 1'b1, 48'd0),
      row_req(16'h0000, TGT_NEG, 8'd0, 1'b0, 1'b1),
      row_req(16'h0100, mscel_pkg::TARGET_POS, 8'hFF, 1'b0, 1'b0),
      row_req(16'h0FFF, TGT_NEG, 8'd0, 1'b0, 1'b0),
      row_req(16'h1000, TGT_NEG, 8'd0, 1'b1, 1'b0),
      row_req(16'hFFFF, mscel_pkg::TARGET_POS, 8'd0, 1'b0, 1'b1),
      row_regs(1'b0, 16'd0),
      row_chk(16'h8000, mscel_pkg::TARGET_POS, 8'd0, 1'b1, 1'b1, 48'd8388608),
      row_regs(1'b0, 16'hFFFF),
      row_chk(16'h8000, mscel_pkg::TARGET_POS, 8'd0, 1'b1, 1'b1, 48'd128),
      row_regs(1'b1, 16'd2),
      row_req(16'h0200, mscel_pkg::TARGET_SKIP, 8'd1, 1'b0, 1'b0),
      row_req(16'h0200, TGT_NEG, 8'd1, 1'b0, 1'b0),
      row_req(16'hFE00, mscel_pkg::TARGET_POS, 8'd1, 1'b1, 1'b0),
      row_req(16'h8000, mscel_pkg::TARGET_SKIP, 8'd0, 1'b0, 1'b0),
      row_regs(1'b0, 16'd3),
      row_req(16'h7FFF, mscel_pkg::TARGET_SKIP, 8'd0, 1'b0, 1'b0),
      row_req(16'h4000, mscel_pkg::TARGET_POS, 8'hFF, 1'b0, 1'b1),
      row_regs(1'b1, 16'd1),
      row_chk(16'h7FFF, mscel_pkg::TARGET_SKIP, 8'd0, 1'b1, 1'b1, 48'd0),
      row_req(16'h0000, mscel_pkg::TARGET_SKIP, 8'hFF, 1'b1, 1'b1)
    };

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < NUM_DIRECTED; i++) begin
      if (directed_steps[i].is_regs) begin
        // The register change may land in the middle of an open batch.
        quiet_down();
        program_regs(directed_steps[i].mode, directed_steps[i].count);
      end else begin
        send_request(directed_steps[i].logit, directed_steps[i].tgt, directed_steps[i].cls,
                     directed_steps[i].eos, directed_steps[i].eob, directed_steps[i].typed,
                     directed_steps[i].mean);
      end
    end

    random_phase(38, 80, 1'b0, 16'd1, 200, 1'b0);
    random_phase(38, 80, 1'b1, 16'd4, 350, 1'b1);
    random_phase(80, 38, 1'b0, 16'hFFFF, 150, 1'b0);
    random_phase(80, 38, 1'b1, 16'd0, 200, 1'b0);
    random_phase(0, 0, 1'b0, 16'($urandom_range(1, 300)), 150, 1'b0);

    // Short batches while the receiver holds off, so that finished means back up, the queue
    // fills and the request channel stalls.
    hold_off_req = 1'b1;
    repeat (48) begin
      eb = 1'($urandom);
      send_request(pick_logit(), mscel_pkg::TARGET_POS, 8'($urandom), eb, eb, 1'b0, '0);
    end

    random_phase(0, 0, 1'b1, 16'd2, 200, 1'b0);
    send_request(pick_logit(), TGT_NEG, 8'd0, 1'b1, 1'b1, 1'b0, '0);
    quiet_down();

    if (err_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
